[rtl/core/minmax_uint8_quantizer_defines.svh]
// assertion macros used by the quantizer top level
`ifndef MINMAX_UINT8_QUANTIZER_DEFINES_SVH
`define MINMAX_UINT8_QUANTIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MMQ_CHECK(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MMQ_CHECK_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mmq_pkg.sv]
// shared types and constants of the min/max uint8 quantizer
package mmq_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CODE_W = 8;
  localparam int CNT_W = 7;
  localparam int MAX_ELEMENTS_DEF = 64;
  // numerator diff*510 + span stays below 2^42
  localparam int NUM_W = 42;
  localparam int DIV_STEPS = 8;
  localparam int STEP_W = 3;

  typedef struct packed {
    logic bank;
    logic [CNT_W-1:0] count;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic dropped;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

[rtl/core/mmq_front.sv]
// load side: sample store, running min/max and tensor bookkeeping
module mmq_front #(
  parameter int MAX_ELEMENTS = mmq_pkg::MAX_ELEMENTS_DEF,
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [mmq_pkg::SAMPLE_W-1:0] sample,
  input  logic final_sample,
  output logic job_push,
  output mmq_pkg::job_t job,
  input  mmq_pkg::release_t rel,
  input  logic [AW:0] rd_addr,
  output logic [mmq_pkg::SAMPLE_W-1:0] rd_data
);
  import mmq_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int DEPTH = 2 * (2 ** AW);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [CW-1:0] fill, fill_next;
  logic signed [SAMPLE_W-1:0] lo, lo_next, hi, hi_next;
  logic ovf, ovf_next;
  logic bank;
  logic [1:0] busy, busy_next;
  logic accept, room, store;

  // a bank stays busy until the back end has emitted all its codes
  assign full = busy[bank];
  assign accept = push & ~full;
  assign room = fill < CW'(MAX_ELEMENTS);
  assign store = accept & room;
  assign job_push = accept & final_sample;

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    fill_next = fill;
    ovf_next = ovf;
    if (store) begin
      if (fill == '0) begin
        lo_next = sample;
        hi_next = sample;
      end else begin
        if (sample < lo) lo_next = sample;
        if (sample > hi) hi_next = sample;
      end
      fill_next = fill + CW'(1);
    end else if (accept) begin
      ovf_next = 1'b1;
    end
  end

  always_comb begin
    job.bank = bank;
    job.count = CNT_W'(fill_next);
    job.lo = lo_next;
    job.hi = hi_next;
    job.dropped = ovf_next;
  end

  always_comb begin
    busy_next = busy;
    if (rel.valid) busy_next[rel.bank] = 1'b0;
    if (job_push) busy_next[bank] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      lo <= '0;
      hi <= '0;
      ovf <= 1'b0;
      bank <= 1'b0;
      busy <= '0;
    end else begin
      busy <= busy_next;
      if (job_push) begin
        fill <= '0;
        lo <= '0;
        hi <= '0;
        ovf <= 1'b0;
        bank <= ~bank;
      end else begin
        fill <= fill_next;
        lo <= lo_next;
        hi <= hi_next;
        ovf <= ovf_next;
      end
    end
  end

  // two banks of the store, one being loaded while the other drains
  always_ff @(posedge clk) begin
    if (store) mem[{bank, fill[AW-1:0]}] <= sample;
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/mmq_job_fifo.sv]
// two-entry queue of finished tensors between load and emit sides
module mmq_job_fifo (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  mmq_pkg::job_t din,
  input  logic pop,
  output logic valid,
  output logic fifo_full,
  output mmq_pkg::job_t head
);
  import mmq_pkg::*;

  job_t q [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign valid = cnt != 2'd0;
  assign fifo_full = cnt == 2'd2;
  assign head = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10: cnt <= cnt + 2'd1;
        2'b01: cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

[rtl/core/mmq_back.sv]
// emit side: reads stored samples and divides out one code per word
module mmq_back #(
  parameter int MAX_ELEMENTS = mmq_pkg::MAX_ELEMENTS_DEF,
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  mmq_pkg::job_t job_in,
  output logic job_pop,
  output logic [AW:0] rd_addr,
  input  logic [mmq_pkg::SAMPLE_W-1:0] rd_data,
  output mmq_pkg::release_t rel,
  output logic empty,
  input  logic pop,
  output logic [mmq_pkg::CODE_W-1:0] code,
  output logic signed [mmq_pkg::SAMPLE_W-1:0] range_low,
  output logic signed [mmq_pkg::SAMPLE_W-1:0] range_high,
  output logic final_code,
  output logic dropped
);
  import mmq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0] st;
  job_t jb;
  logic [AW-1:0] k;
  logic [NUM_W-1:0] rem, dsh;
  logic [CODE_W-1:0] q;
  logic [STEP_W-1:0] step;
  logic flat;
  logic out_valid, out_free, put, last;
  logic [SAMPLE_W-1:0] span, diff;
  logic ge;

  assign job_pop = (st == S_IDLE) & job_valid;
  assign rd_addr = {jb.bank, k};
  assign span = jb.hi - jb.lo;
  assign diff = rd_data - jb.lo;
  assign ge = rem >= dsh;
  assign last = (CNT_W'(k) + CNT_W'(1)) == jb.count;
  assign out_free = ~out_valid | pop;
  assign put = (st == S_PUT) & out_free;
  assign rel.valid = put & last;
  assign rel.bank = jb.bank;
  assign empty = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      k <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (job_valid) begin
            k <= '0;
            st <= S_READ;
          end
        end
        S_READ: st <= S_LOAD;
        S_LOAD: st <= S_DIV;
        S_DIV: begin
          if (step == '0) st <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            if (last) begin
              st <= S_IDLE;
            end else begin
              k <= k + AW'(1);
              st <= S_READ;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // restoring division of diff*510 + span by 2*span, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (job_pop) jb <= job_in;
    if (st == S_LOAD) begin
      rem <= NUM_W'({diff, 9'b0}) - NUM_W'({diff, 1'b0}) + NUM_W'(span);
      dsh <= NUM_W'({span, 8'b0});
      q <= '0;
      step <= STEP_W'(DIV_STEPS - 1);
      flat <= span == '0;
    end else if (st == S_DIV) begin
      if (ge) rem <= rem - dsh;
      q <= {q[CODE_W-2:0], ge};
      dsh <= dsh >> 1;
      step <= step - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      code <= flat ? '0 : q;
      range_low <= jb.lo;
      range_high <= jb.hi;
      final_code <= last;
      dropped <= jb.dropped;
    end
  end

endmodule

[rtl/core/minmax_uint8_quantizer.sv]
// top level of the min/max uint8 quantizer
//
//   channel  handshake     payload
//   input    push / full   sample, final_sample
//   result   pop / empty   code, range_low, range_high, final_code, dropped
//
// an input word is taken every cycle while the bank being loaded is free
// each code goes through store read, operand setup, the one-bit-per-cycle divider's
// 8 steps and the output load, which waits while the previous code is not popped
// the store has two banks, so the next tensor loads while the last one drains
// full rises only when both banks still hold tensors waiting to be emitted
// rst is synchronous; the store is not cleared and needs no sweep after reset
`include "minmax_uint8_quantizer_defines.svh"

module minmax_uint8_quantizer #(
  parameter int MAX_ELEMENTS = mmq_pkg::MAX_ELEMENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [mmq_pkg::SAMPLE_W-1:0] sample,
  input  logic final_sample,
  output logic empty,
  input  logic pop,
  output logic [mmq_pkg::CODE_W-1:0] code,
  output logic signed [mmq_pkg::SAMPLE_W-1:0] range_low,
  output logic signed [mmq_pkg::SAMPLE_W-1:0] range_high,
  output logic final_code,
  output logic dropped
);
  import mmq_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  job_t job_new, job_head;
  release_t rel;
  logic job_push, job_pop, job_valid, fifo_full;
  logic [AW:0] rd_addr;
  logic [SAMPLE_W-1:0] rd_data;

  mmq_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .sample(sample),
    .final_sample(final_sample),
    .job_push(job_push),
    .job(job_new),
    .rel(rel),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mmq_job_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(job_push),
    .din(job_new),
    .pop(job_pop),
    .valid(job_valid),
    .fifo_full(fifo_full),
    .head(job_head)
  );

  mmq_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job_in(job_head),
    .job_pop(job_pop),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .rel(rel),
    .empty(empty),
    .pop(pop),
    .code(code),
    .range_low(range_low),
    .range_high(range_high),
    .final_code(final_code),
    .dropped(dropped)
  );

  `MMQ_CHECK(a_fifo_room, clk, rst, job_push, !fifo_full, "tensor queue overrun")
  `MMQ_CHECK_NEXT(a_job_held, clk, rst, job_push, job_valid, "finished tensor lost")
  `MMQ_CHECK(a_job_nonempty, clk, rst, job_pop, job_head.count != '0, "tensor with no samples")
  `MMQ_CHECK(a_flat_zero, clk, rst, !empty && range_low == range_high, code == '0, "flat code")

endmodule

[tb/tb_top.sv]
// testbench for the min/max uint8 quantizer: directed and random tensors, self-checking
`timescale 1ns / 1ps

module tb_top;
  import mmq_pkg::*;

  localparam int STORE_CAP = MAX_ELEMENTS_DEF;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic is_last;
    logic dropped;
  } code_word_t;

  typedef enum int {
    VALS_WIDE,
    VALS_NARROW,
    VALS_FLAT,
    VALS_EXTREME
  } value_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic final_sample = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [CODE_W-1:0] code;
  logic signed [SAMPLE_W-1:0] range_low;
  logic signed [SAMPLE_W-1:0] range_high;
  logic final_code;
  logic dropped;

  // predictor state
  logic signed [SAMPLE_W-1:0] tensor_store [STORE_CAP];
  int unsigned tensor_fill = 0;
  logic signed [SAMPLE_W-1:0] tensor_lo = '0;
  logic signed [SAMPLE_W-1:0] tensor_hi = '0;
  logic tensor_overflow = 1'b0;

  code_word_t expected_codes [$];
  int unsigned mismatch_count = 0;

  // sender burst shaping
  int unsigned burst_left = 0;
  bit steady_sender = 1'b0;

  // receiver stall pattern
  logic hold_output = 1'b0;
  int unsigned pop_percent = 100;
  int unsigned pattern_left = 0;

  minmax_uint8_quantizer i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .sample(sample),
    .final_sample(final_sample),
    .empty(empty),
    .pop(pop),
    .code(code),
    .range_low(range_low),
    .range_high(range_high),
    .final_code(final_code),
    .dropped(dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  function automatic logic [CODE_W-1:0] quantize_code(longint v, longint lo, longint hi);
    longint unsigned span;
    longint unsigned diff;
    longint unsigned q;
    span = hi - lo;
    diff = v - lo;
    if (span == 0) return '0;
    // half-up rounding of diff*255/span
    q = (diff * 510 + span) / (span * 2);
    if (q > 255) q = 255;
    return q[CODE_W-1:0];
  endfunction

  task automatic predict_codes(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
    code_word_t w;
    if (tensor_fill < STORE_CAP) begin
      tensor_store[tensor_fill] = s;
      if (tensor_fill == 0) begin
        tensor_lo = s;
        tensor_hi = s;
      end else begin
        if (s < tensor_lo) tensor_lo = s;
        if (s > tensor_hi) tensor_hi = s;
      end
      tensor_fill++;
    end else begin
      tensor_overflow = 1'b1;
    end
    if (is_last) begin
      for (int unsigned k = 0; k < tensor_fill; k++) begin
        w.code = quantize_code(tensor_store[k], tensor_lo, tensor_hi);
        w.lo = tensor_lo;
        w.hi = tensor_hi;
        w.is_last = (k + 1 == tensor_fill);
        w.dropped = tensor_overflow;
        expected_codes.push_back(w);
      end
      tensor_fill = 0;
      tensor_lo = '0;
      tensor_hi = '0;
      tensor_overflow = 1'b0;
    end
  endtask

  // offer one word and wait until the block takes it; push stays high for the next word unless a gap is drawn
  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
    int unsigned gap;
    push <= 1'b1;
    sample <= s;
    final_sample <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_codes(s, is_last);
    if (!steady_sender) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(value_mode_t mode,
                                                            logic signed [SAMPLE_W-1:0] base);
    case (mode)
      VALS_NARROW: return base + $urandom_range(0, 40);
      VALS_FLAT: return base;
      VALS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_tensor(input int unsigned len, input value_mode_t mode);
    logic signed [SAMPLE_W-1:0] base;
    base = $urandom;
    for (int unsigned i = 0; i < len; i++) begin
      send_word(pick_sample(mode, base), i + 1 == len);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    // a code still in the divider would show up before this wait ends
    repeat (40) @(posedge clk);
  endtask

  task automatic hold_results(input int unsigned cycles);
    hold_output <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_output <= 1'b0;
  endtask

  // receiver: stall pattern changes every so often, full speed included
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1: pop_percent = 100;
          2: pop_percent = 70;
          3: pop_percent = 40;
          default: pop_percent = 15;
        endcase
        pattern_left = $urandom_range(20, 200);
      end else begin
        pattern_left--;
      end
      pop <= !hold_output && ($urandom_range(0, 99) < pop_percent);
    end
  end

  task automatic report_field(input string name, input logic [SAMPLE_W-1:0] want,
                              input logic [SAMPLE_W-1:0] got);
    $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    mismatch_count++;
  endtask

  // result checker: every word taken is compared with the oldest expectation
  always @(posedge clk) begin
    code_word_t want;
    if (!rst && pop && !empty) begin
      if (expected_codes.size() == 0) begin
        $display("%0t ns: unexpected word, expected none actual code %0h", $time, code);
        mismatch_count++;
      end else begin
        want = expected_codes.pop_front();
        if (code !== want.code) report_field("code", want.code, code);
        if (range_low !== want.lo) report_field("range_low", want.lo, range_low);
        if (range_high !== want.hi) report_field("range_high", want.hi, range_high);
        if (final_code !== want.is_last) report_field("final_code", want.is_last, final_code);
        if (dropped !== want.dropped) report_field("dropped", want.dropped, dropped);
      end
    end
  end

  task automatic test_single_element();
    send_word(32'sh8000_0000, 1'b1);
  endtask

  task automatic test_full_span();
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sh0000_0000, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'shaaaa_aaaa, 1'b1);
  endtask

  task automatic test_flat_tensor();
    repeat (3) send_word(32'sh1234_5678, 1'b0);
    send_word(32'sh1234_5678, 1'b1);
  endtask

  task automatic test_half_ties();
    // midpoint of 0..2 lands exactly between two codes
    send_word(32'sd0, 1'b0);
    send_word(32'sd2, 1'b0);
    send_word(32'sd1, 1'b1);
    send_word(-32'sd5, 1'b0);
    send_word(-32'sd3, 1'b0);
    send_word(-32'sd4, 1'b1);
  endtask

  task automatic test_capacity();
    // store filled exactly, then extra words with out-of-range values, the last one final
    for (int unsigned i = 0; i < STORE_CAP; i++) send_word($urandom_range(100, 1000), 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7fff_ffff, 1'b1);
  endtask

  task automatic test_input_stall();
    wait_drained();
    steady_sender = 1'b1;
    fork
      hold_results(400);
    join_none
    repeat (3) send_tensor(4, VALS_WIDE);
    steady_sender = 1'b0;
  endtask

  task automatic test_random_tensors();
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sent = 0;
    while (sent < 24) begin
      r = $urandom_range(0, 19);
      if (r < 15) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 12);
      steady_sender = ($urandom_range(0, 4) == 0);
      send_tensor(len, value_mode_t'($urandom_range(0, 3)));
      sent += len;
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_element();
    test_full_span();
    test_flat_tensor();
    test_half_ties();
    test_capacity();
    test_input_stall();
    test_random_tensors();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mmq_pkg.sv
rtl/core/mmq_front.sv
rtl/core/mmq_job_fifo.sv
rtl/core/mmq_back.sv
rtl/core/minmax_uint8_quantizer.sv
tb/tb_top.sv
